// ===== src/rbsi_pkg.sv =====
package rbsi_pkg;

  // configuration register map
  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_T_LIMIT  = 3'd6;

  localparam int NUM_AXES = 3;

  // divider stages around the one-bit-per-stage quotient core
  localparam int DIV_PRE_STAGES  = 2;  // magnitudes, overflow compare
  localparam int DIV_POST_STAGES = 1;  // saturate and restore sign

  // stages an axis adds around its dividers
  localparam int AXIS_PRE_STAGES  = 1;  // plane distances
  localparam int AXIS_POST_STAGES = 1;  // slab ordering

endpackage

// ===== src/rbsi_ctrl.sv =====
module rbsi_ctrl
  import rbsi_pkg::*;
#(
  parameter int DEPTH = 39
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  output logic             in_ready,
  output logic [DEPTH-1:0] en,
  output logic [DEPTH-1:0] valid
);

  // a stage may load when it or any later stage up to the output is
  // empty, or when the output is being taken
  for (genvar k = 0; k < DEPTH; k++) begin : g_en
    assign en[k] = !(&valid[DEPTH-1:k]) || out_ready;
  end

  assign in_ready = en[0];

  // valid bits travel with the data, bubbles are squeezed out
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en[0]) begin
      valid[0] <= in_valid;
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_valid
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en[k]) begin
        valid[k] <= valid[k-1];
      end
    end
  end

endmodule

// ===== src/rbsi_div.sv =====
module rbsi_div
  import rbsi_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int LAT         = DIV_PRE_STAGES + COORD_WIDTH + DIV_POST_STAGES
) (
  input  logic                          clk,
  input  logic [LAT-1:0]                en,
  input  logic signed [COORD_WIDTH:0]   num,
  input  logic signed [COORD_WIDTH-1:0] den,
  output logic signed [COORD_WIDTH-1:0] quo
);

  localparam int CW = COORD_WIDTH;
  localparam int NW = CW + 1 + FRAC_BITS;
  localparam int RW = (NW > 2 * CW) ? NW : 2 * CW;

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // magnitudes and result sign
  logic          neg_a;
  logic [CW:0]   nabs_a;
  logic [CW-1:0] dabs_a;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg_a  <= num[CW] ^ den[CW-1];
      nabs_a <= num[CW] ? (~num + 1'b1) : num;
      dabs_a <= den[CW-1] ? (~den + 1'b1) : den;
    end
  end

  // quotient pipeline, stage j resolves bit CW-j
  logic [RW-1:0] rem_s  [0:CW-1];
  logic [CW-1:0] dabs_s [0:CW-1];
  logic [CW-1:0] q_s    [0:CW];
  logic          neg_s  [0:CW];
  logic          over_s [0:CW];

  logic [RW-1:0] num_sh;
  logic [RW-1:0] den_top;

  assign num_sh  = RW'(nabs_a) << FRAC_BITS;
  assign den_top = RW'(dabs_a) << CW;

  // anything at or above 2^CW saturates whatever the low bits are
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem_s[0]  <= num_sh;
      dabs_s[0] <= dabs_a;
      q_s[0]    <= '0;
      neg_s[0]  <= neg_a;
      over_s[0] <= num_sh >= den_top;
    end
  end

  for (genvar j = 1; j <= CW; j++) begin : g_bit
    localparam int BIT = CW - j;
    logic [RW:0] diff;
    logic        take;

    // restoring step: subtract the shifted divisor if it fits
    assign diff = {1'b0, rem_s[j-1]} - {1'b0, (RW'(dabs_s[j-1]) << BIT)};
    assign take = !diff[RW];

    always_ff @(posedge clk) begin
      if (en[DIV_PRE_STAGES+j-1]) begin
        q_s[j]    <= q_s[j-1] | (CW'(take) << BIT);
        neg_s[j]  <= neg_s[j-1];
        over_s[j] <= over_s[j-1];
      end
    end

    if (j < CW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[DIV_PRE_STAGES+j-1]) begin
          rem_s[j]  <= take ? diff[RW-1:0] : rem_s[j-1];
          dabs_s[j] <= dabs_s[j-1];
        end
      end
    end
  end

  // saturate to the signed range, then apply the sign
  logic          sat;
  logic [CW-1:0] qf;

  assign qf  = q_s[CW];
  assign sat = over_s[CW] ||
               (neg_s[CW] ? (qf[CW-1] && (|qf[CW-2:0])) : qf[CW-1]);

  always_ff @(posedge clk) begin
    if (en[LAT-1]) begin
      if (sat) begin
        quo <= neg_s[CW] ? CMIN : CMAX;
      end else begin
        quo <= neg_s[CW] ? (~qf + 1'b1) : qf;
      end
    end
  end

endmodule

// ===== src/rbsi_axis.sv =====
module rbsi_axis
  import rbsi_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int DIV_LAT     = DIV_PRE_STAGES + COORD_WIDTH + DIV_POST_STAGES,
  parameter int LAT         = AXIS_PRE_STAGES + DIV_LAT + AXIS_POST_STAGES
) (
  input  logic                          clk,
  input  logic [LAT-1:0]                en,
  input  logic signed [COORD_WIDTH-1:0] box_min,
  input  logic signed [COORD_WIDTH-1:0] box_max,
  input  logic signed [COORD_WIDTH-1:0] origin,
  input  logic signed [COORD_WIDTH-1:0] dir,
  output logic signed [COORD_WIDTH-1:0] lo,
  output logic signed [COORD_WIDTH-1:0] hi,
  output logic                          miss
);

  localparam int CW = COORD_WIDTH;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic dzero;
    logic miss;
  } slab_flags_t;

  // distances from the origin to both planes, exact in CW+1 bits
  logic signed [CW:0]   dmin;
  logic signed [CW:0]   dmax;
  logic signed [CW-1:0] dir_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dmin  <= {box_min[CW-1], box_min} - {origin[CW-1], origin};
      dmax  <= {box_max[CW-1], box_max} - {origin[CW-1], origin};
      dir_r <= dir;
    end
  end

  // parallel ray: in the slab when box_min <= origin <= box_max
  slab_flags_t flags_in;
  logic        in_slab;

  assign in_slab        = (dmin[CW] || (dmin == '0)) && !dmax[CW];
  assign flags_in.dzero = (dir_r == '0);
  assign flags_in.miss  = (dir_r == '0) && !in_slab;

  // flags ride along with the division
  slab_flags_t flags_s [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en[AXIS_PRE_STAGES]) begin
      flags_s[0] <= flags_in;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_flags
    always_ff @(posedge clk) begin
      if (en[AXIS_PRE_STAGES+k]) begin
        flags_s[k] <= flags_s[k-1];
      end
    end
  end

  // plane crossing times
  logic signed [CW-1:0] t1;
  logic signed [CW-1:0] t2;

  rbsi_div #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .LAT         (DIV_LAT)
  ) u_div_min (
    .clk (clk),
    .en  (en[AXIS_PRE_STAGES+DIV_LAT-1:AXIS_PRE_STAGES]),
    .num (dmin),
    .den (dir_r),
    .quo (t1)
  );

  rbsi_div #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .LAT         (DIV_LAT)
  ) u_div_max (
    .clk (clk),
    .en  (en[AXIS_PRE_STAGES+DIV_LAT-1:AXIS_PRE_STAGES]),
    .num (dmax),
    .den (dir_r),
    .quo (t2)
  );

  // order the slab, parallel ray spans everything
  always_ff @(posedge clk) begin
    if (en[LAT-1]) begin
      if (flags_s[DIV_LAT-1].dzero) begin
        lo <= CMIN;
        hi <= CMAX;
      end else if (t1 < t2) begin
        lo <= t1;
        hi <= t2;
      end else begin
        lo <= t2;
        hi <= t1;
      end
      miss <= flags_s[DIV_LAT-1].miss;
    end
  end

endmodule

// ===== src/ray_box_slab_intersect_core.sv =====
// channel   dir  beat contents
// s_axis    in   one box: min x/y/z, max x/y/z
// m_axis    out  hit flag, entry time, exit time
// apb       in   ray origin, direction, entry time limit
//
// one box per cycle sustained while m_tready is high; latency is set by
// the restoring dividers that resolve one quotient bit per stage, six of
// them side by side
// rst is synchronous: clears the valid bits and loads the register reset
// values; no memory, no clearing pass
// with m_tready low the pipeline closes its bubbles, s_tready drops only
// when every stage holds a box
module ray_box_slab_intersect_core
  import rbsi_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  // hit, t_enter, t_exit
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0]   m_tdata,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [REG_IDX_W+((COORD_WIDTH>32)?3:2)-1:0] paddr,
  input  logic [((COORD_WIDTH>32)?64:32)-1:0]    pwdata,
  output logic [((COORD_WIDTH>32)?64:32)-1:0]    prdata,
  output logic                                   pready
);

  localparam int CW      = COORD_WIDTH;
  localparam int PW      = (CW > 32) ? 64 : 32;
  localparam int SH      = (CW > 32) ? 3 : 2;
  localparam int AW      = REG_IDX_W + SH;
  localparam int OW      = ((2 * CW + 1 + 7) / 8) * 8;
  localparam int DIV_LAT = DIV_PRE_STAGES + CW + DIV_POST_STAGES;
  localparam int AX_LAT  = AXIS_PRE_STAGES + DIV_LAT + AXIS_POST_STAGES;
  localparam int DEPTH   = AX_LAT + 2;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

  // configuration registers
  logic signed [CW-1:0] cfg_origin [NUM_AXES];
  logic signed [CW-1:0] cfg_dir    [NUM_AXES];
  logic signed [CW-1:0] cfg_limit;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;

  assign reg_idx = paddr[AW-1:SH];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cfg_origin[a] <= '0;
        cfg_dir[a]    <= '0;
      end
      cfg_limit <= CMAX;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_ORIGIN_X: cfg_origin[0] <= pwdata[CW-1:0];
        REG_ORIGIN_Y: cfg_origin[1] <= pwdata[CW-1:0];
        REG_ORIGIN_Z: cfg_origin[2] <= pwdata[CW-1:0];
        REG_DIR_X:    cfg_dir[0]    <= pwdata[CW-1:0];
        REG_DIR_Y:    cfg_dir[1]    <= pwdata[CW-1:0];
        REG_DIR_Z:    cfg_dir[2]    <= pwdata[CW-1:0];
        REG_T_LIMIT:  cfg_limit     <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X: prdata = PW'($unsigned(cfg_origin[0]));
      REG_ORIGIN_Y: prdata = PW'($unsigned(cfg_origin[1]));
      REG_ORIGIN_Z: prdata = PW'($unsigned(cfg_origin[2]));
      REG_DIR_X:    prdata = PW'($unsigned(cfg_dir[0]));
      REG_DIR_Y:    prdata = PW'($unsigned(cfg_dir[1]));
      REG_DIR_Z:    prdata = PW'($unsigned(cfg_dir[2]));
      REG_T_LIMIT:  prdata = PW'($unsigned(cfg_limit));
      default:      prdata = '0;
    endcase
  end

  // pipeline control
  logic [DEPTH-1:0] en;
  logic [DEPTH-1:0] valid;

  rbsi_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .in_ready  (s_tready),
    .en        (en),
    .valid     (valid)
  );

  // one slab unit per axis
  logic signed [CW-1:0] lo   [NUM_AXES];
  logic signed [CW-1:0] hi   [NUM_AXES];
  logic                 miss [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbsi_axis #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .DIV_LAT     (DIV_LAT),
      .LAT         (AX_LAT)
    ) u_axis (
      .clk     (clk),
      .en      (en[AX_LAT-1:0]),
      .box_min (s_tdata[a*CW +: CW]),
      .box_max (s_tdata[(NUM_AXES+a)*CW +: CW]),
      .origin  (cfg_origin[a]),
      .dir     (cfg_dir[a]),
      .lo      (lo[a]),
      .hi      (hi[a]),
      .miss    (miss[a])
    );
  end

  // entry is the latest lower time, exit the earliest upper time
  logic signed [CW-1:0] lo01;
  logic signed [CW-1:0] hi01;
  logic signed [CW-1:0] entry;
  logic signed [CW-1:0] exit_t;
  logic                 slab_ok;

  assign lo01 = (lo[0] > lo[1]) ? lo[0] : lo[1];
  assign hi01 = (hi[0] < hi[1]) ? hi[0] : hi[1];

  always_ff @(posedge clk) begin
    if (en[AX_LAT]) begin
      entry   <= (lo01 > lo[2]) ? lo01 : lo[2];
      exit_t  <= (hi01 < hi[2]) ? hi01 : hi[2];
      slab_ok <= !(miss[0] || miss[1] || miss[2]);
    end
  end

  // hit decision, times cleared on a miss
  logic                 out_hit;
  logic signed [CW-1:0] out_enter;
  logic signed [CW-1:0] out_exit;
  logic                 hit_now;

  assign hit_now = slab_ok && (exit_t >= entry) && !exit_t[CW-1] && (entry <= cfg_limit);

  always_ff @(posedge clk) begin
    if (en[DEPTH-1]) begin
      out_hit   <= hit_now;
      out_enter <= hit_now ? entry : '0;
      out_exit  <= hit_now ? exit_t : '0;
    end
  end

  assign m_tvalid = valid[DEPTH-1];
  assign m_tdata  = OW'({out_exit, out_enter, out_hit});

  // a miss never carries times
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_hit |-> (out_enter == '0) && (out_exit == '0))
    else $error("miss result with nonzero times");

  // a hit has an ordered interval in front of the origin, within the limit
  a_hit_interval: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_hit |-> (out_exit >= out_enter) && !out_exit[CW-1] &&
                            (out_enter <= cfg_limit))
    else $error("hit result with an impossible interval");

  // the input is held off only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&valid) && !m_tready)
    else $error("input stalled while the pipeline has a bubble");

  // a new result only comes out of the stage in front of the output
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(valid[DEPTH-2]))
    else $error("result appeared without a box behind it");

endmodule

// ===== test/tb_ray_box_slab_intersect_core.sv =====
`timescale 1ns / 1ps

module tb_ray_box_slab_intersect_core;
  import rbsi_pkg::*;

  localparam int COORD_W        = 32;
  localparam int FRAC           = 16;
  localparam int PIPE_DEPTH     = COORD_W + 7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 13;
  localparam int BOXES_PER_RAY  = 100;

  // index past the register map, writes there must be dropped
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t T_MAX = 32'sh7FFFFFFF;
  localparam coord_t T_MIN = 32'sh80000000;
  localparam coord_t ONE   = 32'sh00010000;

  // lo[0] = min x sits in the lowest bits, same layout as s_tdata
  typedef struct packed {
    coord_t [2:0] hi;
    coord_t [2:0] lo;
  } box_t;

  // hit in bit 0, then t_enter, then t_exit, same layout as m_tdata
  typedef struct packed {
    coord_t t_exit;
    coord_t t_enter;
    logic   hit;
  } slab_result_t;

  typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_HEAVY} idle_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // hit, t_enter, t_exit, zero pad
  logic [71:0]  m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  box_t         box_q[$];
  slab_result_t hit_expect_q[$];
  coord_t       ray_reg [NUM_REGS];
  box_t         box_on_bus;
  idle_mode_t   tx_mode = IDLE_NONE;
  idle_mode_t   rx_mode = IDLE_NONE;
  int           tx_hold = 0;
  int           rx_hold = 0;
  int           errors = 0;
  int           quiet_cycles = 0;

  ray_box_slab_intersect_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sx(coord_t v);
    return longint'(v);
  endfunction

  function automatic coord_t sat_coord(longint v);
    if (v > sx(T_MAX)) return T_MAX;
    if (v < sx(T_MIN)) return T_MIN;
    return coord_t'(v);
  endfunction

  // (num << FRAC) / den, truncated toward zero, saturated to the coordinate range
  function automatic longint plane_time(longint num, longint den);
    bit                neg;
    longint unsigned   n, d, lim, q, r;
    int                i;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    q = n / d;
    r = n % d;
    if (q > lim) return neg ? sx(T_MIN) : sx(T_MAX);
    for (i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
      if (q > lim) return neg ? sx(T_MIN) : sx(T_MAX);
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // slab test of one box against the ray held in ray_reg
  function automatic slab_result_t slab_hit(box_t b);
    longint       t_entry, t_leave, o, d, t1, t2, lo, hi;
    bit           ok;
    int           a;
    slab_result_t res;
    t_entry = sx(T_MIN);
    t_leave = sx(T_MAX);
    ok = 1'b1;
    for (a = 0; a < NUM_AXES; a++) begin
      o = sx(ray_reg[REG_ORIGIN_X + a]);
      d = sx(ray_reg[REG_DIR_X + a]);
      if (d == 0) begin
        // ray parallel to the slab: unbounded if within it, else a miss
        if (!(sx(b.lo[a]) <= o && o <= sx(b.hi[a]))) ok = 1'b0;
        lo = sx(T_MIN);
        hi = sx(T_MAX);
      end else begin
        t1 = plane_time(sx(b.lo[a]) - o, d);
        t2 = plane_time(sx(b.hi[a]) - o, d);
        lo = (t1 < t2) ? t1 : t2;
        hi = (t1 < t2) ? t2 : t1;
      end
      if (lo > t_entry) t_entry = lo;
      if (hi < t_leave) t_leave = hi;
    end
    res = '0;
    if (ok && t_leave >= t_entry && t_leave >= 0 && t_entry <= sx(ray_reg[REG_T_LIMIT])) begin
      res.hit = 1'b1;
      res.t_enter = coord_t'(t_entry);
      res.t_exit = coord_t'(t_leave);
    end
    return res;
  endfunction

  function automatic int draw_gap(idle_mode_t mode);
    case (mode)
      IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 19)) : 0;
      IDLE_HEAVY:  return int'($urandom_range(0, 19));
      default:     return 0;
    endcase
  endfunction

  function automatic coord_t rand_near(int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic coord_t rand_edge();
    case ($urandom_range(0, 6))
      0:       return T_MIN;
      1:       return T_MAX;
      2:       return 0;
      3:       return 1;
      4:       return -1;
      5:       return ONE;
      default: return -ONE;
    endcase
  endfunction

  function automatic box_t mk_box(coord_t x0, coord_t y0, coord_t z0,
                                  coord_t x1, coord_t y1, coord_t z1);
    box_t b;
    b.lo[0] = x0;
    b.lo[1] = y0;
    b.lo[2] = z0;
    b.hi[0] = x1;
    b.hi[1] = y1;
    b.hi[2] = z1;
    return b;
  endfunction

  function automatic box_t cube(coord_t lo, coord_t hi);
    return mk_box(lo, lo, lo, hi, hi, hi);
  endfunction

  // mostly boxes placed along the ray, the rest noise around it and raw values
  function automatic box_t rand_box();
    box_t   b;
    longint tt, p, e1, e2;
    int     a, mode;
    mode = int'($urandom_range(0, 99));
    tt = longint'(int'($urandom_range(0, 45 * ONE))) - 5 * longint'(ONE);
    for (a = 0; a < NUM_AXES; a++) begin
      if (mode < 55) begin
        p = sx(ray_reg[REG_ORIGIN_X + a]) + ((sx(ray_reg[REG_DIR_X + a]) * tt) >>> FRAC);
        e1 = longint'($urandom_range(0, 3 * ONE));
        e2 = longint'($urandom_range(0, 3 * ONE));
        b.lo[a] = sat_coord(p - e1);
        b.hi[a] = sat_coord(p + e2);
      end else if (mode < 75) begin
        p = sx(ray_reg[REG_ORIGIN_X + a]) + sx(rand_near(8 * ONE));
        e1 = longint'($urandom_range(0, 6 * ONE));
        if ($urandom_range(0, 9) == 0) e1 = -e1;
        b.lo[a] = sat_coord(p);
        b.hi[a] = sat_coord(p + e1);
      end else if (mode < 90) begin
        b.lo[a] = coord_t'($urandom);
        b.hi[a] = coord_t'($urandom);
      end else begin
        b.lo[a] = rand_edge();
        b.hi[a] = rand_edge();
      end
    end
    return b;
  endfunction

  function automatic coord_t rand_origin();
    case ($urandom_range(0, 19))
      0, 1, 2: return rand_edge();
      3, 4, 5: return coord_t'($urandom);
      default: return rand_near(20 * ONE);
    endcase
  endfunction

  function automatic coord_t rand_dir();
    case ($urandom_range(0, 19))
      0, 1, 2: return 0;
      3, 4, 5: return rand_edge();
      6, 7:    return rand_near(255);
      8, 9:    return coord_t'($urandom);
      default: return rand_near(4 * ONE);
    endcase
  endfunction

  function automatic coord_t rand_limit();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return T_MAX;
      4:          return rand_edge();
      5:          return coord_t'($urandom);
      default:    return rand_near(40 * ONE);
    endcase
  endfunction

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input coord_t val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx < NUM_REGS) ray_reg[idx] = val;
  endtask

  task automatic apb_check(input logic [REG_IDX_W-1:0] idx);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== ray_reg[idx]) begin
      errors++;
      $display("%0t: register %0d readback expected %h actual %h",
               $time, idx, ray_reg[idx], prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_ray(input coord_t ox, input coord_t oy, input coord_t oz,
                         input coord_t dx, input coord_t dy, input coord_t dz,
                         input coord_t lim);
    coord_t vals [NUM_REGS];
    int     i;
    vals = '{ox, oy, oz, dx, dy, dz, lim};
    for (i = REG_ORIGIN_X; i <= REG_T_LIMIT; i++) apb_write(REG_IDX_W'(i), vals[i]);
    for (i = REG_ORIGIN_X; i <= REG_T_LIMIT; i++) apb_check(REG_IDX_W'(i));
  endtask

  // sender holds off until every box has come back, checked between edges
  task automatic wait_idle();
    while (box_q.size() != 0 || s_tvalid || hit_expect_q.size() != 0) @(negedge clk);
  endtask

  // box driver: one beat per accepted box, random gap after each
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_hold = 0;
    end else begin
      if (s_tvalid && s_tready) hit_expect_q.push_back(slab_hit(box_on_bus));
      if (!s_tvalid || s_tready) begin
        if (tx_hold > 0) begin
          tx_hold--;
          s_tvalid <= 1'b0;
        end else if (box_q.size() > 0) begin
          box_on_bus = box_q.pop_front();
          s_tdata <= box_on_bus;
          s_tvalid <= 1'b1;
          tx_hold = draw_gap(tx_mode);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    slab_result_t got, want;
    if (rst) begin
      rx_hold = 0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[64:0];
        if (hit_expect_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
        end else begin
          want = hit_expect_q.pop_front();
          if (got.hit !== want.hit) begin
            errors++;
            $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
          end
          if (got.t_enter !== want.t_enter) begin
            errors++;
            $display("%0t: t_enter expected %h actual %h", $time, want.t_enter, got.t_enter);
          end
          if (got.t_exit !== want.t_exit) begin
            errors++;
            $display("%0t: t_exit expected %h actual %h", $time, want.t_exit, got.t_exit);
          end
        end
        rx_hold = draw_gap(rx_mode);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      m_tready <= (rx_hold == 0);
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph, i;
    ray_reg = '{0, 0, 0, 0, 0, 0, T_MAX};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset ray has zero direction: every slab is all or nothing
    box_q.push_back(cube(-ONE, ONE));
    box_q.push_back(cube(0, 0));
    box_q.push_back(cube(T_MIN, T_MAX));
    box_q.push_back(mk_box(1, -ONE, -ONE, ONE, ONE, ONE));
    box_q.push_back(mk_box(-ONE, -ONE, -ONE, ONE, -1, ONE));
    box_q.push_back(mk_box(-ONE, -ONE, ONE, ONE, ONE, -ONE));
    wait_idle();

    // write past the map is dropped, then a unit diagonal ray
    apb_write(REG_UNMAPPED, 32'h1234_5678);
    set_ray(0, 0, 0, ONE, ONE, ONE, T_MAX);
    box_q.push_back(cube(2 * ONE, 3 * ONE));
    box_q.push_back(cube(-3 * ONE, -2 * ONE));
    box_q.push_back(cube(-ONE, ONE));
    box_q.push_back(cube(3 * ONE, 2 * ONE));
    box_q.push_back(cube(T_MIN, T_MAX));
    box_q.push_back(mk_box(0, 2 * ONE, 0, ONE, 3 * ONE, 5 * ONE));
    box_q.push_back(mk_box(ONE, 2 * ONE, 0, 2 * ONE, 3 * ONE, 5 * ONE));
    wait_idle();

    // entry right at the limit, one lsb past it, exit at zero
    set_ray(0, 0, 0, ONE, ONE, ONE, 2 * ONE);
    box_q.push_back(cube(2 * ONE, 3 * ONE));
    box_q.push_back(cube(2 * ONE + 1, 3 * ONE));
    box_q.push_back(cube(-ONE, 0));
    wait_idle();

    // tiny directions drive the quotients into saturation, the most negative one keeps them small
    set_ray(ONE, -ONE, 0, 1, -1, T_MIN, T_MIN);
    box_q.push_back(cube(-2 * ONE, 2 * ONE));
    box_q.push_back(cube(T_MIN, T_MAX));
    box_q.push_back(mk_box(ONE, -ONE, 0, ONE, -ONE, 0));
    wait_idle();

    // two edge-case rays, then random rays, each followed by a burst of boxes
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        set_ray(T_MIN, T_MAX, 0, T_MAX, T_MIN, 1, T_MIN);
      else if (ph == 1)
        set_ray(T_MAX, T_MIN, -1, -1, 1, T_MAX, T_MAX);
      else
        set_ray(rand_origin(), rand_origin(), rand_origin(),
                rand_dir(), rand_dir(), rand_dir(), rand_limit());
      tx_mode = (ph == 2) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
      rx_mode = (ph == 2) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
      for (i = 0; i < BOXES_PER_RAY; i++) box_q.push_back(rand_box());
      wait_idle();
    end

    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (errors == 0 && hit_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
